// File: rtl/bqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared widths, codes and controller/datapath command type for the biquad.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int FRAC_W    = 20;
  localparam int STATE_W   = 40;
  localparam int NUM_COEFS = 5;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_arr_t;

  typedef enum logic [2:0] {
    CI_FF0 = 3'd0,
    CI_FF1 = 3'd1,
    CI_FF2 = 3'd2,
    CI_FB1 = 3'd3,
    CI_FB2 = 3'd4
  } coef_idx_e;

  typedef enum logic [1:0] {
    MS_IN,
    MS_X,
    MS_Y
  } mul_src_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROUND,
    OP_SUM1,
    OP_HOLD2,
    OP_SUB1,
    OP_COMMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic      load_x;
    logic      mul_en;
    mul_src_e  mul_src;
    coef_idx_e coef_idx;
    dp_op_e    op;
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/biquad_iir_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Second-order IIR section, transposed direct form II, Q3.20 coefficients.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in        in   in_valid_i/in_ready_o   sample_in_i
//  out       out  out_valid_o/out_ready_i sample_out_o, clipped_o
//  cfg       in   APB psel/penable        five coefficients at 4*i
//
//  The single 16x24 multiplier forms one of the five products per cycle
//  unless stalled. A new word is taken in the last cycle of the previous.
//  Reset clears both delays and loads a0 = 1.0, all other coefficients 0.
//  A full output register holds the last cycle, and input, until it drains.
// ----------------------------------------------------------------------------
module biquad_iir_filter import bqd_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed      [SAMPLE_W-1:0] sample_out_o,
  output logic                            clipped_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic        [PADDR_W-1:0]  paddr,
  input  wire logic        [PDATA_W-1:0]  pwdata,
  output logic             [PDATA_W-1:0]  prdata,
  output logic                            pready
);

  coef_arr_t coefs;
  dp_cmd_t   cmd;

  bqd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs_o (coefs)
  );

  bqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bqd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .coefs_i      (coefs),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_COMMIT) |-> (!out_valid_o || out_ready_i))
    else $error("result overwrites an undelivered word");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_COMMIT) |=> out_valid_o)
    else $error("committed result not presented");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.mul_en |-> (!in_ready_o && out_valid_o && !out_ready_i))
    else $error("multiplier stalled without output backpressure");

endmodule
`default_nettype wire

// File: rtl/bqd_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_regs
// APB coefficient register file: five signed Q3.20 coefficients.
// ----------------------------------------------------------------------------
module bqd_regs import bqd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output coef_arr_t               coefs_o
);

  // a0 = 1.0, all others 0
  localparam coef_arr_t COEFS_RST =
    {{((NUM_COEFS-1)*COEF_W){1'b0}}, COEF_W'(1 << FRAC_W)};

  coef_arr_t coefs_q, coefs_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign coefs_o = coefs_q;

  always_comb begin
    coefs_d = coefs_q;
    if (wr_en) begin
      unique case (idx)
        CI_FF0:  coefs_d[CI_FF0] = pwdata[COEF_W-1:0];
        CI_FF1:  coefs_d[CI_FF1] = pwdata[COEF_W-1:0];
        CI_FF2:  coefs_d[CI_FF2] = pwdata[COEF_W-1:0];
        CI_FB1:  coefs_d[CI_FB1] = pwdata[COEF_W-1:0];
        CI_FB2:  coefs_d[CI_FB2] = pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CI_FF0:  prdata = {{(PDATA_W-COEF_W){1'b0}}, coefs_q[CI_FF0]};
      CI_FF1:  prdata = {{(PDATA_W-COEF_W){1'b0}}, coefs_q[CI_FF1]};
      CI_FF2:  prdata = {{(PDATA_W-COEF_W){1'b0}}, coefs_q[CI_FF2]};
      CI_FB1:  prdata = {{(PDATA_W-COEF_W){1'b0}}, coefs_q[CI_FB1]};
      CI_FB2:  prdata = {{(PDATA_W-COEF_W){1'b0}}, coefs_q[CI_FB2]};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= COEFS_RST;
    end else begin
      coefs_q <= coefs_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bqd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer: one product per cycle via the shared multiplier unless stalled.
// ----------------------------------------------------------------------------
module bqd_ctrl import bqd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output dp_cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    commit     = 1'b0;
    cmd_o      = '{load_x: 1'b0, mul_en: 1'b1, mul_src: MS_IN,
                   coef_idx: CI_FF0, op: OP_NONE};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          state_d      = ST_P1;
        end
      end
      ST_P1: begin
        cmd_o.op       = OP_ROUND;
        cmd_o.mul_src  = MS_X;
        cmd_o.coef_idx = CI_FF1;
        state_d        = ST_P2;
      end
      ST_P2: begin
        cmd_o.op       = OP_SUM1;
        cmd_o.mul_src  = MS_X;
        cmd_o.coef_idx = CI_FF2;
        state_d        = ST_P3;
      end
      ST_P3: begin
        cmd_o.op       = OP_HOLD2;
        cmd_o.mul_src  = MS_Y;
        cmd_o.coef_idx = CI_FB1;
        state_d        = ST_P4;
      end
      ST_P4: begin
        cmd_o.op       = OP_SUB1;
        cmd_o.mul_src  = MS_Y;
        cmd_o.coef_idx = CI_FB2;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          commit     = 1'b1;
          cmd_o.op   = OP_COMMIT;
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load_x = 1'b1;
            state_d      = ST_P1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          // hold last product until the output word drains
          cmd_o.mul_en = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bqd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqd_dp
// Datapath: shared 16x24 multiplier, accumulate/round/saturate, delay state.
// ----------------------------------------------------------------------------
module bqd_dp import bqd_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dp_cmd_t                    cmd_i,
  input  wire coef_arr_t                  coefs_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic signed      [SAMPLE_W-1:0] sample_out_o,
  output logic                            clipped_o
);

  localparam int ACC_W = STATE_W + 2;
  localparam int YSH_W = ACC_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] RND_C = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [YSH_W-1:0] SMAX =
    YSH_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [YSH_W-1:0] SMIN = -SMAX - YSH_W'(1);
  localparam logic signed [ACC_W-1:0] ST_MAX =
    ACC_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ST_MIN = -ST_MAX - ACC_W'(1);

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [STATE_W-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[STATE_W-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  logic signed [SAMPLE_W-1:0] x_q, y_q, y_d, sample_out_q;
  logic                       clip_q, clip_d, clipped_q;
  logic signed [STATE_W-1:0]  prod_q, d1_q, d2_q, t2_q;
  logic signed [ACC_W-1:0]    t1_q;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]   mul_c;
  logic signed [STATE_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]    acc, prod_x, d1_x, d2_x, t2_x;
  logic signed [YSH_W-1:0]    ysh;

  always_comb begin
    case (cmd_i.mul_src)
      MS_X:    mul_a = x_q;
      MS_Y:    mul_a = y_q;
      default: mul_a = sample_in_i;
    endcase
    mul_c = $signed(coefs_i[cmd_i.coef_idx]);
    mul_p = STATE_W'(mul_a * mul_c);
  end

  assign prod_x = ACC_W'(prod_q);
  assign d1_x   = ACC_W'(d1_q);
  assign d2_x   = ACC_W'(d2_q);
  assign t2_x   = ACC_W'(t2_q);

  // round to nearest, ties up: floor((acc + half) / 2^FRAC_W)
  assign acc = prod_x + d1_x + RND_C;
  assign ysh = acc[ACC_W-1:FRAC_W];

  always_comb begin
    if (ysh > SMAX) begin
      y_d    = SMAX[SAMPLE_W-1:0];
      clip_d = 1'b1;
    end else if (ysh < SMIN) begin
      y_d    = SMIN[SAMPLE_W-1:0];
      clip_d = 1'b1;
    end else begin
      y_d    = ysh[SAMPLE_W-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    case (cmd_i.op)
      OP_ROUND: begin
        y_q    <= y_d;
        clip_q <= clip_d;
      end
      OP_SUM1:   t1_q <= prod_x + d2_x;
      OP_HOLD2:  t2_q <= prod_q;
      OP_SUB1:   t1_q <= t1_q - prod_x;
      OP_COMMIT: begin
        sample_out_q <= y_q;
        clipped_q    <= clip_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.op == OP_COMMIT) begin
      d1_q <= sat_state(t1_q);
      d2_q <= sat_state(t2_x - prod_x);
    end
  end

  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule
`default_nettype wire

// File: tb/sv/tb_biquad_iir_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_biquad_iir_filter
// Self-checking bench for the transposed direct form II biquad section.
// A short table of directed words (pass-through after reset, rounding ties,
// coefficient extremes, ignored register writes, saturated feedback) is
// followed by eight random phases. Each phase programs all five coefficients
// over APB and streams samples. Every output word is checked against a value
// from the table or a fixed-point model of the filter kept inside the bench.
// ----------------------------------------------------------------------------
module tb_biquad_iir_filter import bqd_pkg::*; ();

  localparam int     LIMIT       = 500000;
  localparam int     HOLD_CYC    = 400;
  localparam int     TAIL_CYC    = 12;
  localparam int     PHASE_WORDS = 160;
  localparam int     NUM_PHASES  = 8;
  localparam int     REG_SPARE_LO = 5;
  localparam int     REG_SPARE_HI = 7;
  localparam longint ST_MAX = (longint'(1) << (STATE_W - 1)) - 1;
  localparam longint ST_MIN = -ST_MAX - 1;
  localparam longint SMP_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;

  typedef enum int {ROW_CFG, ROW_SMP} row_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_STRIDE} rx_mode_e;
  typedef enum int {CS_LOWPASS, CS_RANDOM, CS_EXTREME, CS_SMALL} coef_set_e;

  typedef struct {
    row_kind_e            kind;
    int                   reg_idx;
    logic [PDATA_W-1:0]   wval;
    logic signed [SAMPLE_W-1:0] x;
    bit                   lit;
    logic signed [SAMPLE_W-1:0] y;
    bit                   clip;
  } dir_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] y;
    logic                       clip;
  } due_word_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       clipped_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [PDATA_W-1:0]         pwdata;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  biquad_iir_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .clipped_o   (clipped_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  coef_t                     coef_q [NUM_COEFS];
  logic signed [STATE_W-1:0] dly1_q;
  logic signed [STATE_W-1:0] dly2_q;
  due_word_t                 due_words [$];

  int  cycles;
  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  clips_seen;
  int  settings_done;
  int  burst_left;
  bit  steady_feed;
  bit  hold_req;

  dir_row_t dir_table [$] = '{
    // pass-through after reset
    '{ROW_SMP, 0, 0, 0,      1, 0,      0},
    '{ROW_SMP, 0, 0, 32767,  1, 32767,  0},
    '{ROW_SMP, 0, 0, -32768, 1, -32768, 0},
    '{ROW_SMP, 0, 0, 1,      1, 1,      0},
    '{ROW_SMP, 0, 0, -1,     1, -1,     0},
    '{ROW_SMP, 0, 0, 21845,  1, 21845,  0},
    '{ROW_SMP, 0, 0, -21846, 1, -21846, 0},
    // a0 = 0.5: halves land on ties, rounded toward +inf
    '{ROW_CFG, CI_FF0, 32'h0008_0000, 0, 0, 0, 0},
    '{ROW_SMP, 0, 0, 1,      1, 1,      0},
    '{ROW_SMP, 0, 0, -1,     1, 0,      0},
    '{ROW_SMP, 0, 0, 3,      1, 2,      0},
    '{ROW_SMP, 0, 0, -3,     1, -1,     0},
    // a0 at max, junk in the upper data bits
    '{ROW_CFG, CI_FF0, 32'hFF7F_FFFF, 0, 0, 0, 0},
    '{ROW_SMP, 0, 0, 32767,  1, 32767,  1},
    '{ROW_SMP, 0, 0, -32768, 1, -32768, 1},
    '{ROW_SMP, 0, 0, 100,    0, 0,      0},
    // writes past the last register do nothing
    '{ROW_CFG, REG_SPARE_LO, 32'h0000_0000, 0, 0, 0, 0},
    '{ROW_CFG, REG_SPARE_HI, 32'h0000_0000, 0, 0, 0, 0},
    '{ROW_SMP, 0, 0, 32767,  1, 32767,  1},
    // a0 at min
    '{ROW_CFG, CI_FF0, 32'h0080_0000, 0, 0, 0, 0},
    '{ROW_SMP, 0, 0, -32768, 1, 32767,  1},
    '{ROW_SMP, 0, 0, 32767,  1, -32768, 1},
    // feedback from a saturated output, first delay pushed to its limit
    '{ROW_CFG, CI_FF1, 32'h007F_FFFF, 0, 0, 0, 0},
    '{ROW_CFG, CI_FF2, 32'h0080_0000, 0, 0, 0, 0},
    '{ROW_CFG, CI_FB1, 32'h0010_0000, 0, 0, 0, 0},
    '{ROW_CFG, CI_FB2, 32'h00F8_0000, 0, 0, 0, 0},
    '{ROW_SMP, 0, 0, 32767,  0, 0,      0},
    '{ROW_SMP, 0, 0, 32767,  0, 0,      0},
    '{ROW_SMP, 0, 0, -32768, 0, 0,      0},
    '{ROW_SMP, 0, 0, 0,      0, 0,      0},
    '{ROW_SMP, 0, 0, 0,      0, 0,      0},
    '{ROW_SMP, 0, 0, 1000,   0, 0,      0}
  };

  function automatic longint clamp_state(input longint v);
    if (v > ST_MAX) return ST_MAX;
    if (v < ST_MIN) return ST_MIN;
    return v;
  endfunction

  function automatic longint coef_mul(input longint s, input coef_idx_e ci);
    return clamp_state(s * longint'(coef_q[ci]));
  endfunction

  function automatic due_word_t biquad_step(input logic signed [SAMPLE_W-1:0] x_in);
    longint    x;
    longint    acc;
    longint    y;
    due_word_t r;
    x = longint'(x_in);
    acc = coef_mul(x, CI_FF0) + longint'(dly1_q);
    y = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    r.clip = 1'b0;
    if (y > SMP_MAX) begin
      y = SMP_MAX;
      r.clip = 1'b1;
    end
    if (y < SMP_MIN) begin
      y = SMP_MIN;
      r.clip = 1'b1;
    end
    dly1_q = STATE_W'(clamp_state(coef_mul(x, CI_FF1) + longint'(dly2_q)
                                  - coef_mul(y, CI_FB1)));
    dly2_q = STATE_W'(clamp_state(coef_mul(x, CI_FF2) - coef_mul(y, CI_FB2)));
    r.y = SAMPLE_W'(y);
    return r;
  endfunction

  task automatic write_coef(input int idx, input logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < NUM_COEFS) coef_q[idx] = val[COEF_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, wait for every due word, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  task automatic send_word(input logic signed [SAMPLE_W-1:0] x, input bit lit,
                           input logic signed [SAMPLE_W-1:0] y_lit, input bit clip_lit);
    due_word_t w;
    int        gap;
    int        r;
    if (burst_left == 0 && !steady_feed) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      gap = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 30);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    w = biquad_step(x);
    if (lit) begin
      w.y    = y_lit;
      w.clip = clip_lit;
    end
    due_words.push_back(w);
    words_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d words still due", cycles, due_words.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin : out_check
    due_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (clipped_o) clips_seen++;
      if (due_words.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected output word y=%0d clip=%0b", sample_out_o, clipped_o);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        words_checked++;
        if (sample_out_o !== want.y || clipped_o !== want.clip) begin
          if (mismatches < 10)
            $display("tb: word %0d mismatch: expected y=%0d clip=%0b, got y=%0d clip=%0b",
                     words_checked, want.y, want.clip, sample_out_o, clipped_o);
          mismatches++;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus one long counted hold-off on request
  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    out_ready_i = 1'b0;
    mode        = RX_OPEN;
    mode_left   = 0;
    tick        = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(30, 150);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 7) == 0);
          default:   out_ready_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    coef_set_e                  phase_set [NUM_PHASES];
    int                         extremes [5];
    int                         c [NUM_COEFS];
    int                         r;
    logic [31:0]                junk;
    logic signed [SAMPLE_W-1:0] x;
    phase_set = '{CS_LOWPASS, CS_RANDOM, CS_EXTREME, CS_SMALL,
                  CS_LOWPASS, CS_EXTREME, CS_SMALL, CS_RANDOM};
    extremes  = '{8388607, -8388608, 0, 1048576, -1048576};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycles        = 0;
    mismatches    = 0;
    words_sent    = 0;
    words_checked = 0;
    clips_seen    = 0;
    settings_done = 1;
    burst_left    = 0;
    steady_feed   = 1'b0;
    hold_req      = 1'b0;
    coef_q[CI_FF0] = coef_t'(1 << FRAC_W);
    coef_q[CI_FF1] = '0;
    coef_q[CI_FF2] = '0;
    coef_q[CI_FB1] = '0;
    coef_q[CI_FB2] = '0;
    dly1_q = '0;
    dly2_q = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        settle();
        write_coef(dir_table[i].reg_idx, dir_table[i].wval);
        settings_done++;
      end else begin
        send_word(dir_table[i].x, dir_table[i].lit, dir_table[i].y, dir_table[i].clip);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (phase_set[ph])
        CS_LOWPASS: begin
          c[CI_FF0] = $urandom_range(1000, 200000);
          c[CI_FF1] = 2 * c[CI_FF0];
          c[CI_FF2] = c[CI_FF0];
          c[CI_FB2] = $urandom_range(209715, 943718);
          c[CI_FB1] = -int'($urandom_range(0, ((1 << FRAC_W) + c[CI_FB2]) / 10 * 9));
        end
        CS_RANDOM: begin
          foreach (c[k]) c[k] = int'($urandom());
        end
        CS_EXTREME: begin
          foreach (c[k]) c[k] = extremes[$urandom_range(0, 4)];
        end
        default: begin
          foreach (c[k]) c[k] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        end
      endcase
      foreach (c[k]) begin
        junk = $urandom();
        write_coef(k, {junk[31:COEF_W], c[k][COEF_W-1:0]});
      end
      settings_done++;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 4 && n == 40) begin
          hold_req    = 1'b1;
          steady_feed = 1'b1;
        end
        if (ph == 4 && n == 80) steady_feed = 1'b0;
        if (ph == 6 && n == 80) settle();
        r = $urandom_range(0, 9);
        case (r)
          0:       x = 16'sh7FFF;
          1:       x = 16'sh8000;
          2, 3:    x = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
          default: x = SAMPLE_W'($urandom());
        endcase
        send_word(x, 1'b0, '0, 1'b0);
      end
    end

    settle();
    mismatches += due_words.size();
    $display("tb: %0d samples sent, %0d output words checked, %0d of them clipped",
             words_sent, words_checked, clips_seen);
    $display("tb: %0d coefficient settings, pass-through, ties, extremes and long stalls",
             settings_done);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
